FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the keypad event engine RTL.
// No dependencies; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/kde_pkg.sv
// Types, codes and constants of the keypad event engine.
// No dependencies.
package kde_pkg;

   localparam int KEY_W = 3;
   localparam int SEQ_W = 32;
   localparam int LEVEL_W = 8;
   localparam int PERIOD_W = 16;
   localparam int EXP_W = 3;
   localparam int PORT_KEYS = 6;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 3;

   localparam logic [LEVEL_W-1:0] DEBOUNCE_FULL_RST = 8'd4;
   localparam logic [PERIOD_W-1:0] REPEAT_PERIOD_RST = 16'd200;
   localparam logic [EXP_W-1:0] LONG_COUNT_RST = 3'd5;
   localparam logic [LEVEL_W-1:0] LEVEL_RST = DEBOUNCE_FULL_RST >> 1;
   localparam logic [SEQ_W-1:0] NEXT_SEQ_RST = 32'd1;

   typedef enum logic {
      OP_SCAN = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      EV_PRESS   = 3'd0,
      EV_RELEASE = 3'd1,
      EV_SHORT   = 3'd2,
      EV_LONG    = 3'd3,
      EV_REPEAT  = 3'd4
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE_FULL   = 3'd0,
      CSR_REPEAT_PERIOD   = 3'd1,
      CSR_LONG_COUNT      = 3'd2,
      CSR_INVERT_MASK     = 3'd3,
      CSR_VIBRO_ENABLE    = 3'd4,
      CSR_VIBRO_TYPE_MASK = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]   debounce_full;
      logic [PERIOD_W-1:0]  repeat_period;
      logic [EXP_W-1:0]     long_count;
      logic [PORT_KEYS-1:0] invert_mask;
      logic                 vibro_enable;
      logic [4:0]           vibro_type_mask;
   } cfg_type;

   // Up to two events per key and word: a (press/short/long/repeat), b (release).
   typedef struct packed {
      logic             a_valid;
      kind_type         a_kind;
      logic             a_vibro;
      logic             b_valid;
      logic             b_vibro;
      logic [SEQ_W-1:0] seq;
   } lane_event_type;

   // Expander pin map: ports 2 and 3 are swapped.
   function automatic logic [2:0] port_bit(input int unsigned key);
      logic [2:0] b;
      case (key)
         2: b = 3'd3;
         3: b = 3'd2;
         default: b = 3'(key);
      endcase
      return b;
   endfunction

   function automatic logic vibro_of(input kind_type kind, input cfg_type cfg);
      logic v;
      case (kind)
         EV_PRESS:   v = cfg.vibro_enable & cfg.vibro_type_mask[0];
         EV_RELEASE: v = cfg.vibro_enable & cfg.vibro_type_mask[1];
         EV_SHORT:   v = cfg.vibro_enable & cfg.vibro_type_mask[2];
         default:    v = 1'b0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/core/kde_lane.sv
// One key lane: debounce integrator, stable level, press timer and sequence.
// Depends on kde_pkg.
module kde_lane
   import kde_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 accept,
   input  op_type               opcode,
   input  logic                 raw,
   input  logic [SEQ_W-1:0]     seq_base,
   input  logic [KEY_W:0]       seq_offset,
   output logic                 press,
   output lane_event_type       events
);

   logic                stable_ff, stable_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [EXP_W-1:0]    expiry_ff, expiry_in;
   logic                running_ff, running_in;
   logic [PERIOD_W-1:0] elapsed_ff, elapsed_in;
   logic [SEQ_W-1:0]    seq_ff, seq_in;

   logic [LEVEL_W-1:0]  d;
   logic                at_rail;
   logic [PERIOD_W:0]   e;
   logic [EXP_W-1:0]    exp_inc;
   logic [SEQ_W-1:0]    seq_new;

   always_comb begin
      if (raw) begin
         d = (level_ff < cfg.debounce_full) ? level_ff + 8'd1 : level_ff;
      end else begin
         d = (level_ff != '0) ? level_ff - 8'd1 : level_ff;
      end
      at_rail = !((d != '0) && (d < cfg.debounce_full));
      e = {1'b0, elapsed_ff} + 17'd1;
      exp_inc = expiry_ff + 3'd1;
      seq_new = seq_base + SEQ_W'(seq_offset);
      press = accept && (opcode == OP_SCAN) && at_rail && raw && !stable_ff;
   end

   always_comb begin
      stable_in = stable_ff;
      level_in = level_ff;
      expiry_in = expiry_ff;
      running_in = running_ff;
      elapsed_in = elapsed_ff;
      seq_in = seq_ff;
      events = '0;
      events.a_kind = EV_PRESS;
      events.seq = seq_ff;
      if (accept) begin
         case (opcode)
            OP_SCAN: begin
               level_in = d;
               if (at_rail && (raw != stable_ff)) begin
                  stable_in = raw;
                  elapsed_in = '0;
                  if (raw) begin
                     seq_in = seq_new;
                     running_in = 1'b1;
                     events.a_valid = 1'b1;
                     events.a_kind = EV_PRESS;
                     events.seq = seq_new;
                  end else begin
                     running_in = 1'b0;
                     events.a_valid = (expiry_ff < cfg.long_count);
                     events.a_kind = EV_SHORT;
                     events.b_valid = 1'b1;
                     expiry_in = '0;
                  end
               end
            end
            OP_TICK: begin
               if (running_ff) begin
                  if (e < {1'b0, cfg.repeat_period}) begin
                     elapsed_in = e[PERIOD_W-1:0];
                  end else begin
                     elapsed_in = '0;
                     if (expiry_ff < cfg.long_count) begin
                        expiry_in = exp_inc;
                        events.a_valid = (exp_inc == cfg.long_count);
                        events.a_kind = EV_LONG;
                     end else begin
                        events.a_valid = 1'b1;
                        events.a_kind = EV_REPEAT;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      events.a_vibro = vibro_of(events.a_kind, cfg);
      events.b_vibro = vibro_of(EV_RELEASE, cfg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= 1'b0;
         level_ff <= LEVEL_RST;
         expiry_ff <= '0;
         running_ff <= 1'b0;
         elapsed_ff <= '0;
         seq_ff <= '0;
      end else begin
         stable_ff <= stable_in;
         level_ff <= level_in;
         expiry_ff <= expiry_in;
         running_ff <= running_in;
         elapsed_ff <= elapsed_in;
         seq_ff <= seq_in;
      end
   end

endmodule

FILE: rtl/core/kde_merge.sv
// Merge stage: holds one word's lane events and sends them out in key order.
// Depends on kde_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kde_merge
   import kde_pkg::*;
#(
   parameter int NUM_KEYS = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  lane_event_type [NUM_KEYS-1:0]   events,
   output logic                            busy,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [KEY_W-1:0]                rsp_key_index,
   output logic [2:0]                      rsp_event_kind,
   output logic [SEQ_W-1:0]                rsp_sequence_number,
   output logic                            rsp_vibro_pulse,
   output logic                            rsp_last_event
);

   localparam int SLOTS = 2 * NUM_KEYS;

   logic [SLOTS-1:0]               pend_ff, pend_in;
   lane_event_type [NUM_KEYS-1:0]  rec_ff;
   logic [SLOTS-1:0]               new_mask;
   logic [SLOTS-1:0]               sel_onehot;
   logic [KEY_W-1:0]               sel_key;
   kind_type                       sel_kind;
   logic [SEQ_W-1:0]               sel_seq;
   logic                           sel_vibro;
   logic                           sel_last;
   logic                           emit;

   logic                           valid_ff, valid_in;
   logic [KEY_W-1:0]               key_ff;
   kind_type                       kind_ff;
   logic [SEQ_W-1:0]               seq_ff;
   logic                           vibro_ff;
   logic                           last_ff;

   always_comb begin
      for (int k = 0; k < NUM_KEYS; k++) begin
         new_mask[2*k] = events[k].a_valid;
         new_mask[2*k+1] = events[k].b_valid;
      end
   end

   // lowest pending slot wins
   always_comb begin
      sel_onehot = '0;
      sel_key = '0;
      sel_kind = EV_PRESS;
      sel_seq = '0;
      sel_vibro = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            sel_onehot = SLOTS'(1) << i;
            sel_key = KEY_W'(i >> 1);
            sel_seq = rec_ff[i >> 1].seq;
            if ((i % 2) == 1) begin
               sel_kind = EV_RELEASE;
               sel_vibro = rec_ff[i >> 1].b_vibro;
            end else begin
               sel_kind = rec_ff[i >> 1].a_kind;
               sel_vibro = rec_ff[i >> 1].a_vibro;
            end
         end
      end
      sel_last = ((pend_ff & ~sel_onehot) == '0);
      emit = (pend_ff != '0) && (!valid_ff || !rsp_stall);
      busy = (pend_ff != '0) && !(emit && sel_last);
   end

   always_comb begin
      pend_in = pend_ff;
      if (emit) begin
         pend_in = pend_ff & ~sel_onehot;
      end
      if (load) begin
         pend_in = new_mask;
      end
      valid_in = valid_ff && rsp_stall;
      if (emit) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff <= events;
      end
      if (emit) begin
         key_ff <= sel_key;
         kind_ff <= sel_kind;
         seq_ff <= sel_seq;
         vibro_ff <= sel_vibro;
         last_ff <= sel_last;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_key_index = key_ff;
   assign rsp_event_kind = kind_ff;
   assign rsp_sequence_number = seq_ff;
   assign rsp_vibro_pulse = vibro_ff;
   assign rsp_last_event = last_ff;

   `ASSERT_IMPLIES(a_load_when_free, clock, reset, load, (pend_ff == '0) || (emit && sel_last))
   `ASSERT_NEXT(a_last_marked, clock, reset, emit && sel_last, rsp_valid && rsp_last_event)
   `ASSERT_NEXT(a_pend_hold, clock, reset, !load && !emit, pend_ff == $past(pend_ff))
   `ASSERT_IMPLIES(a_more_pending, clock, reset, rsp_valid && !rsp_last_event, pend_ff != '0)

endmodule

FILE: rtl/core/keypad_debounce_event_generator_core.sv
// Keypad event engine: NUM_KEYS lanes debounce keys read from an 8-bit expander
// port (pins 2 and 3 swapped, per-key inversion) and time held keys. A scan word
// yields Press, or Short (unless Long was reached) then Release, per changed key;
// a tick word yields Long or Repeat per expiring key. Events leave one per cycle
// in key order while rsp_stall is low, the last one of a word flagged. A word is
// taken when req_stall is low; the merge stage holds one word's events, so a
// word with n events (n up to 2*NUM_KEYS) keeps req_stall high until its last
// event leaves the merge stage, and words without events go at one per cycle.
// Depends on kde_pkg, kde_lane and kde_merge.
module keypad_debounce_event_generator_core
   import kde_pkg::*;
#(
   parameter int NUM_KEYS = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_opcode,
   input  logic [7:0]              req_port_sample,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [KEY_W-1:0]        rsp_key_index,
   output logic [2:0]              rsp_event_kind,
   output logic [SEQ_W-1:0]        rsp_sequence_number,
   output logic                    rsp_vibro_pulse,
   output logic                    rsp_last_event
);

   cfg_type                        cfg_ff, cfg_in;
   logic [SEQ_W-1:0]               next_seq_ff, next_seq_in;
   logic                           accept;
   logic                           busy;
   op_type                         opcode;
   logic [NUM_KEYS-1:0]            raw;
   logic [NUM_KEYS-1:0]            press;
   logic [KEY_W:0]                 offset [NUM_KEYS];
   logic [KEY_W:0]                 press_total;
   lane_event_type [NUM_KEYS-1:0]  events;

   assign accept = req_valid && !busy;
   assign req_stall = busy;
   assign opcode = op_type'(req_opcode);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DEBOUNCE_FULL:   cfg_in.debounce_full = csr_wdata[LEVEL_W-1:0];
            CSR_REPEAT_PERIOD:   cfg_in.repeat_period = csr_wdata[PERIOD_W-1:0];
            CSR_LONG_COUNT:      cfg_in.long_count = csr_wdata[EXP_W-1:0];
            CSR_INVERT_MASK:     cfg_in.invert_mask = csr_wdata[PORT_KEYS-1:0];
            CSR_VIBRO_ENABLE:    cfg_in.vibro_enable = csr_wdata[0];
            CSR_VIBRO_TYPE_MASK: cfg_in.vibro_type_mask = csr_wdata[4:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_full <= DEBOUNCE_FULL_RST;
         cfg_ff.repeat_period <= REPEAT_PERIOD_RST;
         cfg_ff.long_count <= LONG_COUNT_RST;
         cfg_ff.invert_mask <= '0;
         cfg_ff.vibro_enable <= 1'b0;
         cfg_ff.vibro_type_mask <= '0;
         next_seq_ff <= NEXT_SEQ_RST;
      end else begin
         cfg_ff <= cfg_in;
         next_seq_ff <= next_seq_in;
      end
   end

   // press numbers are handed out in key order within a word
   always_comb begin
      press_total = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         offset[k] = press_total;
         press_total = press_total + (KEY_W + 1)'(press[k]);
      end
      next_seq_in = next_seq_ff + SEQ_W'(press_total);
   end

   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
      if (k < PORT_KEYS) begin : g_port
         assign raw[k] = req_port_sample[port_bit(k)] ^ cfg_ff.invert_mask[k];
      end else begin : g_none
         assign raw[k] = 1'b0;
      end

      kde_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .cfg        (cfg_ff),
         .accept     (accept),
         .opcode     (opcode),
         .raw        (raw[k]),
         .seq_base   (next_seq_ff),
         .seq_offset (offset[k]),
         .press      (press[k]),
         .events     (events[k])
      );
   end

   kde_merge #(
      .NUM_KEYS (NUM_KEYS)
   ) u_merge (
      .clock               (clock),
      .reset               (reset),
      .load                (accept),
      .events              (events),
      .busy                (busy),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_key_index       (rsp_key_index),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_sequence_number (rsp_sequence_number),
      .rsp_vibro_pulse     (rsp_vibro_pulse),
      .rsp_last_event      (rsp_last_event)
   );

endmodule

FILE: verif/tb_keypad_debounce_event_generator_core.sv
// Testbench for keypad_debounce_event_generator_core: directed table, then random scan/tick
// traffic under several register settings, each event checked against an in-bench predictor.
// Depends on kde_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_keypad_debounce_event_generator_core;
   import kde_pkg::*;

   localparam int NUM_KEYS = 6;
   localparam int SETTLE_CYCLES = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef struct packed {
      logic [2:0]  key;
      kind_type    kind;
      logic [31:0] seq;
      logic        vibro;
      logic        is_last;
   } key_event_type;

   typedef struct packed {
      bit            is_csr;
      csr_index_type idx;
      logic [15:0]   data;
      op_type        op;
      logic [7:0]    port;
      bit            typed;
      bit            typed_event;
      logic [2:0]    t_key;
      kind_type      t_kind;
      logic [31:0]   t_seq;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_DEBOUNCE_FULL;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_opcode = OP_SCAN;
   logic [7:0]             req_port_sample = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [KEY_W-1:0]       rsp_key_index;
   logic [2:0]             rsp_event_kind;
   logic [SEQ_W-1:0]       rsp_sequence_number;
   logic                   rsp_vibro_pulse;
   logic                   rsp_last_event;

   keypad_debounce_event_generator_core #(.NUM_KEYS(NUM_KEYS)) uut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_port_sample(req_port_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_key_index(rsp_key_index),
      .rsp_event_kind(rsp_event_kind),
      .rsp_sequence_number(rsp_sequence_number),
      .rsp_vibro_pulse(rsp_vibro_pulse),
      .rsp_last_event(rsp_last_event)
   );

   always #1 clock = ~clock;

   // Predictor state and register copy
   logic [7:0]  cfg_full;
   logic [15:0] cfg_period;
   logic [2:0]  cfg_long;
   logic [5:0]  cfg_invert;
   logic        cfg_vibro_en;
   logic [4:0]  cfg_vibro_mask;

   logic [5:0]  key_stable;
   logic [5:0]  timer_on;
   logic [7:0]  key_level [NUM_KEYS];
   logic [2:0]  expiry [NUM_KEYS];
   logic [15:0] elapsed [NUM_KEYS];
   logic [31:0] key_seq [NUM_KEYS];
   logic [31:0] next_seq;

   key_event_type pending_events[$];
   key_event_type word_events[$];
   stim_row_type  directed[$];

   int mismatch_count = 0;
   int quiet_cycles = 0;
   bit idle_on = 1'b1;
   bit long_hold_req = 1'b0;

   task automatic note_event(input int unsigned k, input kind_type kind);
      key_event_type ev;
      ev.key = 3'(k);
      ev.kind = kind;
      ev.seq = key_seq[k];
      ev.vibro = (kind == EV_PRESS || kind == EV_RELEASE || kind == EV_SHORT) ?
                 (cfg_vibro_en & cfg_vibro_mask[kind]) : 1'b0;
      ev.is_last = 1'b0;
      word_events.push_back(ev);
   endtask

   // Events caused by one word, in key order; last one flagged
   task automatic advance_keypad(input op_type op, input logic [7:0] port);
      int unsigned k;
      int unsigned pin;
      logic r;
      logic [7:0] d;
      logic [16:0] e;
      key_event_type tail;
      word_events.delete();
      for (k = 0; k < NUM_KEYS; k++) begin
         if (op == OP_SCAN) begin
            pin = (k == 2) ? 3 : (k == 3) ? 2 : k;
            r = port[pin] ^ cfg_invert[k];
            d = key_level[k];
            if (r) begin
               if (d < cfg_full) d = d + 8'd1;
            end else if (d > 0) begin
               d = d - 8'd1;
            end
            key_level[k] = d;
            if (!(d > 0 && d < cfg_full) && key_stable[k] != r) begin
               key_stable[k] = r;
               elapsed[k] = '0;
               if (r) begin
                  key_seq[k] = next_seq;
                  next_seq = next_seq + 32'd1;
                  timer_on[k] = 1'b1;
                  note_event(k, EV_PRESS);
               end else begin
                  timer_on[k] = 1'b0;
                  if (expiry[k] < cfg_long) note_event(k, EV_SHORT);
                  note_event(k, EV_RELEASE);
                  expiry[k] = '0;
               end
            end
         end else if (timer_on[k]) begin
            e = {1'b0, elapsed[k]} + 17'd1;
            if (e < {1'b0, cfg_period}) begin
               elapsed[k] = e[15:0];
            end else begin
               elapsed[k] = '0;
               if (expiry[k] < cfg_long) begin
                  expiry[k] = expiry[k] + 3'd1;
                  if (expiry[k] == cfg_long) note_event(k, EV_LONG);
               end else begin
                  note_event(k, EV_REPEAT);
               end
            end
         end
      end
      if (word_events.size() > 0) begin
         tail = word_events.pop_back();
         tail.is_last = 1'b1;
         word_events.push_back(tail);
      end
   endtask

   function automatic stim_row_type word_row(input op_type op, input logic [7:0] port);
      stim_row_type row;
      row = '0;
      row.op = op;
      row.port = port;
      return row;
   endfunction

   function automatic stim_row_type typed_row(input op_type op, input logic [7:0] port,
                                              input bit has_event, input logic [2:0] key,
                                              input kind_type kind, input logic [31:0] seq);
      stim_row_type row;
      row = word_row(op, port);
      row.typed = 1'b1;
      row.typed_event = has_event;
      row.t_key = key;
      row.t_kind = kind;
      row.t_seq = seq;
      return row;
   endfunction

   function automatic stim_row_type csr_row(input csr_index_type idx,
                                            input logic [15:0] data);
      stim_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.idx = idx;
      row.data = data;
      return row;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input stim_row_type row);
      key_event_type ev;
      req_valid <= 1'b1;
      req_opcode <= row.op;
      req_port_sample <= row.port;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_keypad(row.op, row.port);
      if (row.typed) begin
         if (row.typed_event) begin
            ev.key = row.t_key;
            ev.kind = row.t_kind;
            ev.seq = row.t_seq;
            ev.vibro = 1'b0;
            ev.is_last = 1'b1;
            pending_events.push_back(ev);
         end
      end else begin
         foreach (word_events[i]) pending_events.push_back(word_events[i]);
      end
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [15:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_DEBOUNCE_FULL:   cfg_full = data[7:0];
         CSR_REPEAT_PERIOD:   cfg_period = data;
         CSR_LONG_COUNT:      cfg_long = data[2:0];
         CSR_INVERT_MASK:     cfg_invert = data[5:0];
         CSR_VIBRO_ENABLE:    cfg_vibro_en = data[0];
         CSR_VIBRO_TYPE_MASK: cfg_vibro_mask = data[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic apply_config(input logic [7:0] full, input logic [15:0] period,
                               input logic [2:0] lcount, input logic [5:0] inv,
                               input logic ven, input logic [4:0] vmask);
      settle();
      write_register(CSR_DEBOUNCE_FULL, 16'(full));
      write_register(CSR_REPEAT_PERIOD, period);
      write_register(CSR_LONG_COUNT, 16'(lcount));
      write_register(CSR_INVERT_MASK, 16'(inv));
      write_register(CSR_VIBRO_ENABLE, 16'(ven));
      write_register(CSR_VIBRO_TYPE_MASK, 16'(vmask));
   endtask

   task automatic apply_random_config();
      apply_config(8'($urandom_range(1, 5)), 16'($urandom_range(1, 4)),
                   3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                   1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
   endtask

   // Mostly held key patterns that drift one bit at a time, plus ticks and noise
   task automatic run_traffic(input int words, input bit hold_rsp);
      int i;
      int pick;
      int run_left;
      int max_run;
      logic [7:0] pattern;
      pattern = 8'($urandom_range(0, 255));
      run_left = 0;
      max_run = (cfg_full > 6) ? 8 : cfg_full + 2;
      for (i = 0; i < words; i++) begin
         if (hold_rsp && i == 2) long_hold_req = 1'b1;
         if (idle_on && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            send_word(word_row(OP_TICK, 8'($urandom_range(0, 255))));
         end else if (pick < 35) begin
            send_word(word_row(OP_SCAN, 8'($urandom_range(0, 255))));
         end else begin
            if (run_left == 0) begin
               if ($urandom_range(0, 4) < 3)
                  pattern = pattern ^ (8'd1 << $urandom_range(0, 7));
               else
                  pattern = 8'($urandom_range(0, 255));
               run_left = $urandom_range(1, max_run);
            end
            run_left--;
            send_word(word_row(OP_SCAN, pattern));
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : check_events
      key_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            $display("%0t ns: unexpected event, expected none, actual key %0d kind %0d seq %0d",
                     $time, rsp_key_index, rsp_event_kind, rsp_sequence_number);
            mismatch_count++;
         end else begin
            want = pending_events.pop_front();
            check_field("key_index", 32'(want.key), 32'(rsp_key_index));
            check_field("event_kind", 32'(want.kind), 32'(rsp_event_kind));
            check_field("sequence_number", want.seq, rsp_sequence_number);
            check_field("vibro_pulse", 32'(want.vibro), 32'(rsp_vibro_pulse));
            check_field("last_event", 32'(want.is_last), 32'(rsp_last_event));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Result side back-pressure
   always begin
      @(negedge clock);
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         rsp_stall <= 1'b1;
         repeat (LONG_HOLD_CYCLES) @(negedge clock);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(0, 11)) @(negedge clock);
      end else begin
         rsp_stall <= 1'b0;
         repeat ($urandom_range(0, 15)) @(negedge clock);
      end
   end

   initial begin : main
      bit prev_csr;
      int p;
      cfg_full = DEBOUNCE_FULL_RST;
      cfg_period = REPEAT_PERIOD_RST;
      cfg_long = LONG_COUNT_RST;
      cfg_invert = '0;
      cfg_vibro_en = 1'b0;
      cfg_vibro_mask = '0;
      key_stable = '0;
      timer_on = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         key_level[k] = LEVEL_RST;
         expiry[k] = '0;
         elapsed[k] = '0;
         key_seq[k] = '0;
      end
      next_seq = NEXT_SEQ_RST;

      // Reset settings: integrator starts mid-scale, key 0 needs four held scans
      directed.push_back(typed_row(OP_SCAN, 8'h00, 1'b0, 3'd0, EV_PRESS, 32'd0));
      directed.push_back(typed_row(OP_SCAN, 8'h00, 1'b0, 3'd0, EV_PRESS, 32'd0));
      directed.push_back(typed_row(OP_SCAN, 8'h01, 1'b0, 3'd0, EV_PRESS, 32'd0));
      directed.push_back(typed_row(OP_SCAN, 8'h01, 1'b0, 3'd0, EV_PRESS, 32'd0));
      directed.push_back(typed_row(OP_SCAN, 8'h01, 1'b0, 3'd0, EV_PRESS, 32'd0));
      directed.push_back(typed_row(OP_SCAN, 8'h01, 1'b1, 3'd0, EV_PRESS, 32'd1));
      directed.push_back(typed_row(OP_TICK, 8'hFF, 1'b0, 3'd0, EV_PRESS, 32'd0));
      directed.push_back(csr_row(CSR_VIBRO_ENABLE, 16'd1));
      directed.push_back(csr_row(CSR_VIBRO_TYPE_MASK, 16'h001F));
      directed.push_back(csr_row(CSR_REPEAT_PERIOD, 16'd1));
      directed.push_back(csr_row(CSR_LONG_COUNT, 16'd2));
      directed.push_back(csr_row(CSR_DEBOUNCE_FULL, 16'd1));
      // long, repeat, release from above full scale (no short), all keys press, all long
      directed.push_back(word_row(OP_TICK, 8'h00));
      directed.push_back(word_row(OP_TICK, 8'h00));
      directed.push_back(word_row(OP_TICK, 8'h00));
      directed.push_back(word_row(OP_SCAN, 8'h00));
      directed.push_back(word_row(OP_SCAN, 8'hFF));
      directed.push_back(word_row(OP_TICK, 8'hFF));
      directed.push_back(word_row(OP_TICK, 8'h00));
      // zero full scale, zero period, zero long count
      directed.push_back(csr_row(CSR_LONG_COUNT, 16'd0));
      directed.push_back(csr_row(CSR_REPEAT_PERIOD, 16'd0));
      directed.push_back(csr_row(CSR_DEBOUNCE_FULL, 16'd0));
      directed.push_back(word_row(OP_TICK, 8'h00));
      directed.push_back(word_row(OP_SCAN, 8'h0C));
      // inverted polarity, max long count; ends with short+release on every key
      directed.push_back(csr_row(CSR_INVERT_MASK, 16'h003F));
      directed.push_back(csr_row(CSR_LONG_COUNT, 16'd7));
      directed.push_back(csr_row(CSR_DEBOUNCE_FULL, 16'd2));
      directed.push_back(word_row(OP_SCAN, 8'h00));
      directed.push_back(word_row(OP_SCAN, 8'h00));
      directed.push_back(word_row(OP_SCAN, 8'h55));
      directed.push_back(word_row(OP_SCAN, 8'hFF));
      directed.push_back(word_row(OP_SCAN, 8'hFF));
      directed.push_back(word_row(OP_TICK, 8'hAA));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      prev_csr = 1'b0;
      foreach (directed[i]) begin
         if (directed[i].is_csr) begin
            if (!prev_csr) settle();
            write_register(directed[i].idx, directed[i].data);
         end else begin
            send_word(directed[i]);
         end
         prev_csr = directed[i].is_csr;
      end

      apply_config(8'd3, 16'd2, 3'd2, 6'($urandom_range(0, 63)), 1'b1,
                   5'($urandom_range(0, 31)));
      run_traffic(25, 1'b0);
      apply_config(8'd1, 16'd1, 3'd1, 6'h3F, 1'b1, 5'h1F);
      run_traffic(25, 1'b1);
      apply_config(8'd255, 16'hFFFF, 3'd7, 6'h00, 1'b0, 5'h00);
      run_traffic(20, 1'b0);
      for (p = 0; p < 4; p++) begin
         apply_random_config();
         run_traffic(25, 1'b0);
      end
      apply_random_config();
      idle_on = 1'b0;
      run_traffic(25, 1'b0);

      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (mismatch_count == 0 && pending_events.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
